/* hdl/julian_to_gregorian_date_macros.svh */
// assertion helpers for the julian to gregorian date converter
`ifndef JULIAN_TO_GREGORIAN_DATE_MACROS_SVH
`define JULIAN_TO_GREGORIAN_DATE_MACROS_SVH

`ifndef SYNTHESIS
// checked out of reset only
`define J2G_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("j2g: assertion failed");
// checked on every edge, reset included
`define J2G_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("j2g: assertion failed");
`else
`define J2G_ASSERT(lbl, prop)
`define J2G_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* hdl/j2g_pkg.sv */
package j2g_pkg;

  // field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned KEY_W   = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned DATA_W  = 24;

  // pipeline depth
  localparam int unsigned NUM_STAGES = 10;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [KEY_W-1:0]   key_t;

  // days per four centuries and per four years, with fixed-point reciprocals
  // (2^32 / 146097 and 2^28 / 1461, rounded down)
  localparam logic [17:0] D_CENT = 18'd146097;
  localparam logic [14:0] K_CENT = 15'd29398;
  localparam logic [10:0] D_QUAD = 11'd1461;
  localparam logic [17:0] K_QUAD = 18'd183734;

  // months
  localparam month_t M_FEB = 4'd2;
  localparam month_t M_DEC = 4'd12;

  // sortable date key
  function automatic key_t date_key(input year_t y, input month_t m, input day_t d);
    date_key = {y, m, d};
  endfunction

  // accepted window: first and last julian date
  localparam key_t KEY_FIRST = {14'd1582, 4'd10, 5'd4};
  localparam key_t KEY_LAST  = {14'd9999, 4'd12, 5'd30};

  // julian month length, zero for a month that does not exist
  function automatic day_t jul_month_len(input month_t m, input logic leap);
    day_t len;
    len = '0;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      M_FEB:                                      len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    jul_month_len = len;
  endfunction

  // days from march 1 to the start of a march-based month (0 = march)
  function automatic logic [8:0] month_start(input month_t mm);
    logic [8:0] s;
    s = '0;
    unique case (mm)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = '0;
    endcase
    month_start = s;
  endfunction

endpackage

/* hdl/julian_to_gregorian_date.sv */
// Converts a Julian calendar date to the Gregorian date of the same day, with Julian
// 1582-10-04 paired to Gregorian 1582-10-15. Only dates valid in the Julian calendar
// from 1582-10-04 to 9999-12-30 produce an output transaction; any other input
// transaction is consumed and dropped. The converter takes one date per clock unless
// every stage is full and the output is stalled. A date passes through the stage
// registers p0 to p9 in order, and p9 drives the output transaction. The depth
// of 10 stages comes from the day-number arithmetic: the day count is split into
// centuries and then into four-year blocks, each by a reciprocal multiply, a multiply
// back and a one-step correction, every multiply in a stage of its own. A stage holds
// its item while the next is full and stalled, so bubbles close up under backpressure.
module julian_to_gregorian_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // jul_year[13:0], jul_month[17:14], jul_day[22:18], 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // greg_year[13:0], greg_month[17:14], greg_day[22:18], 0
);

  localparam int unsigned NS = j2g_pkg::NUM_STAGES;

  // stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] adv;

  // input fields
  j2g_pkg::year_t  in_year;
  j2g_pkg::month_t in_month;
  j2g_pkg::day_t   in_day;

  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];

  // stage registers
  logic [13:0] p0_ym_r;
  logic [8:0]  p0_ofs_r;
  logic [23:0] p1_n_r;
  logic [23:0] p2_n_r;
  logic [6:0]  p2_q_r;
  logic [23:0] p3_n_r;
  logic [6:0]  p3_q_r;
  logic [24:0] p3_x_r;
  logic [6:0]  p4_b_r;
  logic [15:0] p4_c_r;
  logic [6:0]  p5_b_r;
  logic [15:0] p5_c_r;
  logic [6:0]  p5_dd_r;
  logic [6:0]  p6_b_r;
  logic [15:0] p6_c_r;
  logic [6:0]  p6_dd_r;
  logic [17:0] p6_x_r;
  logic [6:0]  p7_b_r;
  logic [6:0]  p7_dd_r;
  logic [8:0]  p7_e_r;
  logic [13:0] p8_yp_r;
  logic [8:0]  p8_e_r;
  logic [3:0]  p8_gm_r;
  j2g_pkg::year_t  p9_year_r;
  j2g_pkg::month_t p9_month_r;
  j2g_pkg::day_t   p9_day_r;

  // next values
  logic [13:0] p0_ym_nxt;
  logic [8:0]  p0_ofs_nxt;
  logic        p0_ok;
  logic [23:0] p1_n_nxt;
  logic [6:0]  p2_q_nxt;
  logic [24:0] p3_x_nxt;
  logic [6:0]  p4_b_nxt;
  logic [15:0] p4_c_nxt;
  logic [6:0]  p5_dd_nxt;
  logic [17:0] p6_x_nxt;
  logic [6:0]  p7_dd_nxt;
  logic [8:0]  p7_e_nxt;
  logic [13:0] p8_yp_nxt;
  logic [3:0]  p8_gm_nxt;
  j2g_pkg::year_t  p9_year_nxt;
  j2g_pkg::month_t p9_month_nxt;
  j2g_pkg::day_t   p9_day_nxt;

  // flow control: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_comb begin
    v_nxt[0] = adv[0] ? (in_tvalid && p0_ok) : v_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: validity check, march-based year and day offset within the year
  always_comb begin
    logic   early;
    j2g_pkg::month_t mm;
    j2g_pkg::day_t mlen;
    j2g_pkg::key_t key;
    early = (in_month <= j2g_pkg::M_FEB);
    mlen  = j2g_pkg::jul_month_len(in_month, in_year[1:0] == 2'b00);
    key   = j2g_pkg::date_key(in_year, in_month, in_day);
    p0_ok = (in_month != '0) && (in_month <= j2g_pkg::M_DEC) &&
            (in_day != '0) && (in_day <= mlen) &&
            (key >= j2g_pkg::KEY_FIRST) && (key <= j2g_pkg::KEY_LAST);
    mm         = early ? in_month + 4'd9 : in_month - 4'd3;
    p0_ym_nxt  = in_year - 14'(early);
    p0_ofs_nxt = j2g_pkg::month_start(mm) + 9'(in_day);
  end

  // stage 1: day count from march 1 of year 0 (minus one), scaled to 4a+3
  always_comb begin
    logic [21:0] a;
    a = 22'(p0_ym_r) * 22'd365 + 22'(p0_ym_r[13:2]) + 22'(p0_ofs_r) - 22'd2;
    p1_n_nxt = {a, 2'b11};
  end

  // stage 2: century estimate by reciprocal multiply
  always_comb begin
    logic [38:0] prod;
    prod     = 39'(p1_n_r) * 39'(j2g_pkg::K_CENT);
    p2_q_nxt = prod[38:32];
  end

  // stage 3: multiply the estimate back
  assign p3_x_nxt = 25'(p2_q_r) * 25'(j2g_pkg::D_CENT);

  // stage 4: remainder and one-step correction, day within the century
  always_comb begin
    logic [24:0] r;
    logic [24:0] rc;
    logic        big;
    r        = 25'(p3_n_r) - p3_x_r;
    big      = (r >= 25'(j2g_pkg::D_CENT));
    rc       = big ? r - 25'(j2g_pkg::D_CENT) : r;
    p4_b_nxt = p3_q_r + 7'(big);
    p4_c_nxt = rc[17:2];
  end

  // stage 5: four-year block estimate by reciprocal multiply
  always_comb begin
    logic [35:0] prod;
    prod      = 36'({p4_c_r, 2'b11}) * 36'(j2g_pkg::K_QUAD);
    p5_dd_nxt = prod[34:28];
  end

  // stage 6: multiply the estimate back
  assign p6_x_nxt = 18'(p5_dd_r) * 18'(j2g_pkg::D_QUAD);

  // stage 7: remainder and correction, day within the march-based year
  always_comb begin
    logic [17:0] r;
    logic [17:0] rc;
    logic        big;
    r         = {p6_c_r, 2'b11} - p6_x_r;
    big       = (r >= 18'(j2g_pkg::D_QUAD));
    rc        = big ? r - 18'(j2g_pkg::D_QUAD) : r;
    p7_dd_nxt = p6_dd_r + 7'(big);
    p7_e_nxt  = rc[10:2];
  end

  // stage 8: march-based month by threshold compares, year before the january carry
  always_comb begin
    logic [3:0] gm;
    gm = '0;
    for (int k = 1; k < 12; k++) begin
      gm = gm + 4'(p7_e_r >= j2g_pkg::month_start(4'(k)));
    end
    p8_gm_nxt = gm;
    p8_yp_nxt = 14'(p7_b_r) * 14'd100 + 14'(p7_dd_r);
  end

  // stage 9: calendar month, day and year
  always_comb begin
    logic       late;
    logic [8:0] d9;
    late         = (p8_gm_r >= 4'd10);
    d9           = p8_e_r - j2g_pkg::month_start(p8_gm_r) + 9'd1;
    p9_year_nxt  = p8_yp_r + 14'(late);
    p9_month_nxt = late ? p8_gm_r - 4'd9 : p8_gm_r + 4'd3;
    p9_day_nxt   = d9[4:0];
  end

  // payload registers, loaded when their stage advances
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_ym_r  <= p0_ym_nxt;
      p0_ofs_r <= p0_ofs_nxt;
    end
    if (adv[1]) begin
      p1_n_r <= p1_n_nxt;
    end
    if (adv[2]) begin
      p2_n_r <= p1_n_r;
      p2_q_r <= p2_q_nxt;
    end
    if (adv[3]) begin
      p3_n_r <= p2_n_r;
      p3_q_r <= p2_q_r;
      p3_x_r <= p3_x_nxt;
    end
    if (adv[4]) begin
      p4_b_r <= p4_b_nxt;
      p4_c_r <= p4_c_nxt;
    end
    if (adv[5]) begin
      p5_b_r  <= p4_b_r;
      p5_c_r  <= p4_c_r;
      p5_dd_r <= p5_dd_nxt;
    end
    if (adv[6]) begin
      p6_b_r  <= p5_b_r;
      p6_c_r  <= p5_c_r;
      p6_dd_r <= p5_dd_r;
      p6_x_r  <= p6_x_nxt;
    end
    if (adv[7]) begin
      p7_b_r  <= p6_b_r;
      p7_dd_r <= p7_dd_nxt;
      p7_e_r  <= p7_e_nxt;
    end
    if (adv[8]) begin
      p8_yp_r <= p8_yp_nxt;
      p8_e_r  <= p7_e_r;
      p8_gm_r <= p8_gm_nxt;
    end
    if (adv[9]) begin
      p9_year_r  <= p9_year_nxt;
      p9_month_r <= p9_month_nxt;
      p9_day_r   <= p9_day_nxt;
    end
  end

  // output transaction
  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {1'b0, p9_day_r, p9_month_r, p9_year_r};

  // checks
  `include "julian_to_gregorian_date_macros.svh"

  `J2G_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid)
  `J2G_ASSERT(a_hold_first, v_r[0] && !adv[0] |=> v_r[0] && $stable(p0_ym_r))
  `J2G_ASSERT(a_century_rem, v_r[4] |-> p4_c_r <= 16'd36524)
  `J2G_ASSERT(a_year_rem, v_r[7] |-> p7_e_r <= 9'd365)
  `J2G_ASSERT(a_out_range, out_tvalid |-> |p9_month_r && p9_month_r <= j2g_pkg::M_DEC && |p9_day_r)

endmodule
